// ===== rtl/kcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcp_pkg
// shared types, constants and saturating fixed-point helpers of the
// rate crossing predictor
// ----------------------------------------------------------------------------
package kcp_pkg;

  localparam int TIME_BITS      = 48;
  localparam int RATE_FRAC_BITS = 48;
  localparam int FIELD_BITS     = 48;

  localparam logic [5:0] SH_ZERO = 6'd0;
  localparam logic [5:0] SH_Q16  = 6'd16;
  localparam logic [5:0] SH_RATE = 6'(RATE_FRAC_BITS);
  localparam logic [5:0] SH_POS  = 6'(RATE_FRAC_BITS - 16);

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] ONE_RATE = 64'sd1 <<< RATE_FRAC_BITS;

  localparam logic [TIME_BITS-1:0] TIME_ALL_ONES = {TIME_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0] TIME_SAT      = TIME_ALL_ONES - 1'b1;

  // result status codes
  localparam logic [2:0] ST_SEEDED       = 3'd0;
  localparam logic [2:0] ST_UPDATED      = 3'd1;
  localparam logic [2:0] ST_REJECTED     = 3'd2;
  localparam logic [2:0] ST_NOT_READY    = 3'd3;
  localparam logic [2:0] ST_CROSSED      = 3'd4;
  localparam logic [2:0] ST_EXTRAPOLATED = 3'd5;
  localparam logic [2:0] ST_SATURATED    = 3'd6;

  // request types
  localparam logic REQ_OBSERVE = 1'b0;
  localparam logic REQ_PREDICT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_OBS_NOISE  = 2'd0;
  localparam logic [1:0] CFG_PROC_POS   = 2'd1;
  localparam logic [1:0] CFG_PROC_RATE  = 2'd2;
  localparam logic [1:0] CFG_INIT_RATEV = 2'd3;

  typedef struct packed {
    logic              start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [5:0]         sh;
  } op_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] value;
  } op_rsp_t;

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    mag = a[63] ? (64'd0 - $unsigned(a)) : $unsigned(a);
  endfunction

  function automatic logic signed [63:0] from_mag(input logic [63:0] hi,
                                                  input logic [63:0] lo,
                                                  input logic neg);
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (hi != 64'd0 || lo > lim) begin
      from_mag = neg ? S64_MIN : S64_MAX;
    end else begin
      from_mag = neg ? $signed(64'd0 - lo) : $signed(lo);
    end
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      sadd = a[63] ? S64_MIN : S64_MAX;
    end else begin
      sadd = r;
    end
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) begin
      ssub = a[63] ? S64_MIN : S64_MAX;
    end else begin
      ssub = r;
    end
  endfunction

  function automatic logic signed [63:0] to_q16(input logic [FIELD_BITS-1:0] v);
    if (v[FIELD_BITS-1]) begin
      to_q16 = S64_MAX;
    end else begin
      to_q16 = $signed({v, 16'd0});
    end
  endfunction

endpackage

// ===== rtl/kcp_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcp_mul
// shared 64x64 signed multiplier: four 32x32 partial products, then round
// half away from zero, shift right and saturate
// ----------------------------------------------------------------------------
module kcp_mul (
  input  logic             clk,
  input  logic             rst,
  input  kcp_pkg::op_req_t req,
  output kcp_pkg::op_rsp_t rsp
);
  import kcp_pkg::*;

  logic         busy;
  logic [2:0]   ph;
  logic [63:0]  xa;
  logic [63:0]  xb;
  logic         neg;
  logic [5:0]   sh;
  logic [127:0] acc;
  logic         done;
  logic signed [63:0] value;

  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;
  logic [1:0]   pos;
  logic [127:0] half;
  logic [127:0] shifted;

  assign pa      = ph[1] ? xa[63:32] : xa[31:0];
  assign pb      = ph[0] ? xb[63:32] : xb[31:0];
  assign pp      = pa * pb;
  assign pos     = {1'b0, ph[1]} + {1'b0, ph[0]};
  assign half    = (128'd1 << sh) >> 1;
  assign shifted = acc >> sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ph   <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        ph   <= 3'd0;
      end else if (busy) begin
        if (ph == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        ph <= ph + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      xa  <= mag(req.a);
      xb  <= mag(req.b);
      neg <= req.a[63] ^ req.b[63];
      sh  <= req.sh;
      acc <= 128'd0;
    end else if (busy) begin
      if (ph < 3'd4) begin
        acc <= acc + ({64'd0, pp} << {pos, 5'd0});
      end else if (ph == 3'd4) begin
        acc <= acc + half;
      end else begin
        value <= from_mag(shifted[127:64], shifted[63:0], neg);
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

// ===== rtl/kcp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcp_div
// shared restoring divider: (n << sh) / d, truncating, saturating,
// one quotient bit per cycle
// ----------------------------------------------------------------------------
module kcp_div (
  input  logic             clk,
  input  logic             rst,
  input  kcp_pkg::op_req_t req,
  output kcp_pkg::op_rsp_t rsp
);
  import kcp_pkg::*;

  logic         busy;
  logic [5:0]   cnt;
  logic [63:0]  rem;
  logic [63:0]  lo;
  logic [63:0]  q;
  logic [63:0]  dv;
  logic         neg;
  logic         done;
  logic signed [63:0] value;

  logic [127:0] wide;
  logic [64:0]  trial;
  logic         ge;
  logic [63:0]  q_next;

  assign wide   = {64'd0, mag(req.a)} << req.sh;
  assign trial  = {rem, lo[63]};
  assign ge     = trial >= {1'b0, dv};
  assign q_next = {q[62:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (wide[127:64] >= $unsigned(req.b)) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= 6'd63;
        end
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= wide[127:64];
      lo    <= wide[63:0];
      q     <= 64'd0;
      dv    <= $unsigned(req.b);
      neg   <= req.a[63];
      value <= req.a[63] ? S64_MIN : S64_MAX;
    end else if (busy) begin
      rem <= ge ? 64'(trial - {1'b0, dv}) : trial[63:0];
      lo  <= {lo[62:0], 1'b0};
      q   <= q_next;
      if (cnt == 6'd0) begin
        value <= from_mag(64'd0, q_next, neg);
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

// ===== rtl/kalman_rate_crossing_predictor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_rate_crossing_predictor
// two-state constant-velocity tracker of progress position against wall
// clock, with crossing-time prediction
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready) takes one request beat: req_type selects
//   observe (observed_position, wall_clock) or predict (target_position).
//   out channel (out_valid/out_ready) returns one beat per request with
//   status and crossing_time (zero for observe).
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the noise
//   and seed registers; it is always ready. The user must see that it is
//   written only while idle; the block itself does not enforce this.
// timing: one request at a time; in_ready is high only while idle.
//   seed, reject, not-ready and already-crossed answers go from S_CHECK
//   straight to S_DONE, which raises out_valid, without a shared unit.
//   a predict runs the shared divider once; the divider stops at once when
//   the quotient saturates. a full update runs nine multiplies on the shared
//   multiplier and two 64-bit divides (none if innovation variance <= 0).
// reset: filter unseeded, estimates zero, registers at their defaults.
// a stalled out beat holds status and crossing_time until taken, and no new
// request is taken meanwhile.
// ----------------------------------------------------------------------------
module kalman_rate_crossing_predictor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [kcp_pkg::FIELD_BITS-1:0]    observed_position,
  input  logic [kcp_pkg::FIELD_BITS-1:0]    wall_clock,
  input  logic [kcp_pkg::FIELD_BITS-1:0]    target_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        status,
  output logic [kcp_pkg::FIELD_BITS-1:0]    crossing_time,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [31:0]                       cfg_data
);
  import kcp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_ISSUE = 5'b00100,
    S_WAIT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    STEP_M1, STEP_M2, STEP_M3, STEP_M4, STEP_D1, STEP_D2,
    STEP_M5, STEP_M6, STEP_M7, STEP_M8, STEP_M9, STEP_P1
  } step_t;

  state_t state;
  step_t  step;

  logic [31:0] obs_noise;
  logic [31:0] proc_pos;
  logic [31:0] proc_rate;
  logic [31:0] init_ratev;

  logic               seeded;
  logic signed [63:0] pos_est;
  logic signed [63:0] rate_est;
  logic signed [63:0] pos_var;
  logic signed [63:0] pos_rate_cov;
  logic signed [63:0] rate_var;
  logic [TIME_BITS-1:0] last_wall;

  logic                  req_r;
  logic [FIELD_BITS-1:0] obs_r;
  logic [TIME_BITS-1:0]  wc_r;
  logic [FIELD_BITS-1:0] tgt_r;

  logic [TIME_BITS-1:0] dt;
  logic signed [63:0] ppos;
  logic signed [63:0] pvp;
  logic signed [63:0] pcov;
  logic signed [63:0] pvr;
  logic signed [63:0] innov;
  logic signed [63:0] sv;
  logic signed [63:0] gp;
  logic signed [63:0] gr;
  logic signed [63:0] omg;
  logic signed [63:0] rv_dt;

  op_req_t mul_req;
  op_req_t div_req;
  op_rsp_t mul_rsp;
  op_rsp_t div_rsp;

  logic signed [63:0] z;
  logic signed [63:0] tq;
  logic signed [63:0] dt_s;
  logic signed [63:0] sv_calc;
  logic signed [63:0] rate_floor;
  logic               is_div;
  logic               unit_done;
  logic signed [63:0] res;
  logic [63:0]        q_u;

  assign z          = to_q16(obs_r);
  assign tq         = to_q16(tgt_r);
  assign dt_s       = $signed({{(64-TIME_BITS){1'b0}}, dt});
  assign sv_calc    = sadd(pvp, $signed({32'd0, obs_noise}));
  assign rate_floor = (rate_est < 64'sd1) ? 64'sd1 : rate_est;
  assign is_div     = (step == STEP_D1) || (step == STEP_D2) || (step == STEP_P1);
  assign unit_done  = is_div ? div_rsp.done : mul_rsp.done;
  assign res        = is_div ? div_rsp.value : mul_rsp.value;
  assign q_u        = $unsigned(div_rsp.value);

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign cfg_ready = 1'b1;

  // operand selection for the shared units
  always_comb begin
    mul_req       = '0;
    div_req       = '0;
    mul_req.start = (state == S_ISSUE) && !is_div;
    case (step)
      STEP_M1: begin
        mul_req.a = dt_s;      mul_req.b = rate_est;  mul_req.sh = SH_POS;
      end
      STEP_M2: begin
        mul_req.a = pos_rate_cov; mul_req.b = dt_s;   mul_req.sh = SH_ZERO;
      end
      STEP_M3: begin
        mul_req.a = rate_var;  mul_req.b = dt_s;      mul_req.sh = SH_ZERO;
      end
      STEP_M4: begin
        mul_req.a = rv_dt;     mul_req.b = dt_s;      mul_req.sh = SH_ZERO;
      end
      STEP_D1: begin
        div_req.start = (state == S_ISSUE) && (sv_calc > 64'sd0);
        div_req.a = pvp;       div_req.b = sv_calc;   div_req.sh = SH_RATE;
      end
      STEP_D2: begin
        div_req.start = (state == S_ISSUE);
        div_req.a = pcov;      div_req.b = sv;        div_req.sh = SH_RATE;
      end
      STEP_M5: begin
        mul_req.a = gp;        mul_req.b = innov;     mul_req.sh = SH_RATE;
      end
      STEP_M6: begin
        mul_req.a = gr;        mul_req.b = innov;     mul_req.sh = SH_Q16;
      end
      STEP_M7: begin
        mul_req.a = omg;       mul_req.b = pvp;       mul_req.sh = SH_RATE;
      end
      STEP_M8: begin
        mul_req.a = omg;       mul_req.b = pcov;      mul_req.sh = SH_RATE;
      end
      STEP_M9: begin
        mul_req.a = gr;        mul_req.b = pcov;      mul_req.sh = SH_RATE;
      end
      STEP_P1: begin
        div_req.start = (state == S_ISSUE);
        div_req.a = ssub(tq, pos_est); div_req.b = rate_floor;
        div_req.sh = SH_POS;
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  kcp_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  kcp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      obs_noise  <= 32'd65536;
      proc_pos   <= 32'd65536;
      proc_rate  <= 32'd66;
      init_ratev <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OBS_NOISE:  obs_noise  <= cfg_data;
        CFG_PROC_POS:   proc_pos   <= cfg_data;
        CFG_PROC_RATE:  proc_rate  <= cfg_data;
        CFG_INIT_RATEV: init_ratev <= cfg_data;
        default:        obs_noise  <= obs_noise;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= STEP_M1;
      seeded       <= 1'b0;
      pos_est      <= 64'sd0;
      rate_est     <= 64'sd0;
      pos_var      <= 64'sd0;
      pos_rate_cov <= 64'sd0;
      rate_var     <= 64'sd0;
      last_wall    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          crossing_time <= '0;
          if (req_r == REQ_OBSERVE) begin
            if (!seeded) begin
              pos_est      <= z;
              rate_est     <= 64'sd0;
              pos_var      <= $signed({32'd0, obs_noise});
              pos_rate_cov <= 64'sd0;
              rate_var     <= $signed({32'd0, init_ratev});
              last_wall    <= wc_r;
              seeded       <= 1'b1;
              status       <= ST_SEEDED;
              state        <= S_DONE;
            end else if (wc_r <= last_wall) begin
              status <= ST_REJECTED;
              state  <= S_DONE;
            end else begin
              dt    <= wc_r - last_wall;
              step  <= STEP_M1;
              state <= S_ISSUE;
            end
          end else begin
            if (!seeded) begin
              status        <= ST_NOT_READY;
              crossing_time <= TIME_ALL_ONES;
              state         <= S_DONE;
            end else if (tq <= pos_est) begin
              status        <= ST_CROSSED;
              crossing_time <= last_wall;
              state         <= S_DONE;
            end else begin
              step  <= STEP_P1;
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (step == STEP_D1) begin
            sv <= sv_calc;
            if (sv_calc > 64'sd0) begin
              state <= S_WAIT;
            end else begin
              // degenerate innovation variance: gains set to zero
              gp   <= 64'sd0;
              gr   <= 64'sd0;
              step <= STEP_M5;
            end
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (unit_done) begin
            state <= S_ISSUE;
            case (step)
              STEP_M1: begin
                ppos <= sadd(pos_est, res);
                step <= STEP_M2;
              end
              STEP_M2: begin
                pvp   <= sadd(sadd(pos_var, res), res);
                pvr   <= sadd(rate_var, $signed({32'd0, proc_rate}));
                innov <= ssub(z, ppos);
                step  <= STEP_M3;
              end
              STEP_M3: begin
                rv_dt <= res;
                pcov  <= sadd(pos_rate_cov, res);
                step  <= STEP_M4;
              end
              STEP_M4: begin
                pvp  <= sadd(sadd(pvp, res), $signed({32'd0, proc_pos}));
                step <= STEP_D1;
              end
              STEP_D1: begin
                gp   <= res;
                step <= STEP_D2;
              end
              STEP_D2: begin
                gr   <= res;
                step <= STEP_M5;
              end
              STEP_M5: begin
                pos_est <= sadd(ppos, res);
                step    <= STEP_M6;
              end
              STEP_M6: begin
                rate_est <= sadd(rate_est, res);
                omg      <= ssub(ONE_RATE, gp);
                step     <= STEP_M7;
              end
              STEP_M7: begin
                pos_var <= res;
                step    <= STEP_M8;
              end
              STEP_M8: begin
                pos_rate_cov <= res;
                step         <= STEP_M9;
              end
              STEP_M9: begin
                rate_var  <= ssub(pvr, res);
                last_wall <= wc_r;
                status    <= ST_UPDATED;
                state     <= S_DONE;
              end
              STEP_P1: begin
                if (q_u >= {{(64-TIME_BITS){1'b0}}, TIME_SAT} ||
                    {{(64-TIME_BITS){1'b0}}, last_wall} >=
                    ({{(64-TIME_BITS){1'b0}}, TIME_SAT} - q_u)) begin
                  status        <= ST_SATURATED;
                  crossing_time <= TIME_SAT;
                end else begin
                  status        <= ST_EXTRAPOLATED;
                  crossing_time <= last_wall + q_u[TIME_BITS-1:0];
                end
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request beat capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= req_type;
      obs_r <= observed_position;
      wc_r  <= wall_clock[TIME_BITS-1:0];
      tgt_r <= target_position;
    end
  end

endmodule

// ===== verif/kalman_rate_crossing_predictor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_rate_crossing_predictor_tb
// drives observe and predict beats through the tracker under random idling,
// a long output stall and four register settings, and checks every out beat
// against directed rows or a bit-accurate fixed-point filter model in the bench
// ----------------------------------------------------------------------------
module kalman_rate_crossing_predictor_tb;
  import kcp_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic [47:0] ALL48 = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [2:0]  st;
    logic [47:0] t;
  } answer_t;

  typedef struct {
    logic        req;
    logic [47:0] obs;
    logic [47:0] wc;
    logic [47:0] tgt;
    bit          known;
    logic [2:0]  st;
    logic [47:0] t;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_OBSERVE;
  logic [47:0] observed_position = '0;
  logic [47:0] wall_clock = '0;
  logic [47:0] target_position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [47:0] crossing_time;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_OBS_NOISE;
  logic [31:0] cfg_data = '0;

  kalman_rate_crossing_predictor dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // filter copy and register copy
  bit                 f_seeded;
  logic signed [63:0] f_pos, f_rate, f_pv, f_pc, f_rv;
  logic [47:0]        f_last;
  logic [31:0]        r_noise, r_qpos, r_qrate, r_rv0;

  answer_t     pending_answers[$];
  int          errors = 0;
  int          snd_idle = 10;
  int          rcv_idle = 54;
  logic        hold_req = 1'b0;
  bit          hold_done;
  int          hold_left;
  longint      cycles = 0;
  stim_row_t   dir_rows[$];
  logic [47:0] wc_now, pos_now;
  int          rate_now;

  function automatic logic [63:0] abs64(input logic signed [63:0] a);
    return a[63] ? 64'd0 - a : a;
  endfunction

  function automatic logic signed [63:0] clamp_mag(input logic [127:0] m, input logic neg);
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (m[127:64] != 0 || m[63:0] > lim) return neg ? S64_MIN : S64_MAX;
    return neg ? 64'd0 - m[63:0] : m[63:0];
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] r;
    r = {a[63], a} + {b[63], b};
    if (r[64] != r[63]) return r[64] ? S64_MIN : S64_MAX;
    return r[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] r;
    r = {a[63], a} - {b[63], b};
    if (r[64] != r[63]) return r[64] ? S64_MIN : S64_MAX;
    return r[63:0];
  endfunction

  // product shifted right, rounded half away from zero
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b, input int s);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    if (s != 0) p = (p + (128'd1 << (s - 1))) >> s;
    return clamp_mag(p, a[63] ^ b[63]);
  endfunction

  // numerator shifted left, divided and truncated; d is positive
  function automatic logic signed [63:0] fx_div(input logic signed [63:0] n,
                                                input logic signed [63:0] d, input int s);
    logic [127:0] num;
    num = {64'd0, abs64(n)} << s;
    if (num[127:64] >= d) return n[63] ? S64_MIN : S64_MAX;
    return clamp_mag(num / {64'd0, d}, n[63]);
  endfunction

  function automatic logic signed [63:0] pos_q16(input logic [47:0] v);
    if (v[47]) return S64_MAX;
    return {16'd0, v} << 16;
  endfunction

  task automatic filter_reset();
    f_seeded = 0;
    {f_pos, f_rate, f_pv, f_pc, f_rv} = '0;
    f_last = '0;
    r_noise = 32'd65536;
    r_qpos = 32'd65536;
    r_qrate = 32'd66;
    r_rv0 = 32'hFFFF_FFFF;
  endtask

  task automatic filter_observe(input logic [47:0] obs, input logic [47:0] wc,
                                output answer_t ans);
    logic signed [63:0] z, dt, ppos, pvp, pcov, pvr, innov, sv, gp, gr, omg;
    z = pos_q16(obs);
    ans.t = '0;
    gp = 0;
    gr = 0;
    if (!f_seeded) begin
      f_pos = z;
      f_rate = 0;
      f_pv = {32'd0, r_noise};
      f_pc = 0;
      f_rv = {32'd0, r_rv0};
      f_last = wc;
      f_seeded = 1;
      ans.st = ST_SEEDED;
    end else if (wc <= f_last) begin
      ans.st = ST_REJECTED;
    end else begin
      dt = {16'd0, wc - f_last};
      ppos = sat_add(f_pos, fx_mul(dt, f_rate, RATE_FRAC_BITS - 16));
      pvp = sat_add(f_pv, fx_mul(f_pc, dt, 0));
      pvp = sat_add(pvp, fx_mul(f_pc, dt, 0));
      pvp = sat_add(pvp, fx_mul(fx_mul(f_rv, dt, 0), dt, 0));
      pvp = sat_add(pvp, {32'd0, r_qpos});
      pcov = sat_add(f_pc, fx_mul(f_rv, dt, 0));
      pvr = sat_add(f_rv, {32'd0, r_qrate});
      innov = sat_sub(z, ppos);
      sv = sat_add(pvp, {32'd0, r_noise});
      if (sv > 0) begin
        gp = fx_div(pvp, sv, RATE_FRAC_BITS);
        gr = fx_div(pcov, sv, RATE_FRAC_BITS);
      end
      f_pos = sat_add(ppos, fx_mul(gp, innov, RATE_FRAC_BITS));
      f_rate = sat_add(f_rate, fx_mul(gr, innov, 16));
      omg = sat_sub(ONE_RATE, gp);
      f_pv = fx_mul(omg, pvp, RATE_FRAC_BITS);
      f_pc = fx_mul(omg, pcov, RATE_FRAC_BITS);
      f_rv = sat_sub(pvr, fx_mul(gr, pcov, RATE_FRAC_BITS));
      f_last = wc;
      ans.st = ST_UPDATED;
    end
  endtask

  task automatic filter_crossing(input logic [47:0] tgt, output answer_t ans);
    logic signed [63:0] t, r;
    logic [63:0] q, sat;
    sat = {16'd0, TIME_SAT};
    t = pos_q16(tgt);
    if (!f_seeded) begin
      ans.st = ST_NOT_READY;
      ans.t = TIME_ALL_ONES;
    end else if (t <= f_pos) begin
      ans.st = ST_CROSSED;
      ans.t = f_last;
    end else begin
      r = (f_rate < 1) ? 64'sd1 : f_rate;
      q = fx_div(sat_sub(t, f_pos), r, RATE_FRAC_BITS - 16);
      if (q >= sat || {16'd0, f_last} >= sat - q) begin
        ans.st = ST_SATURATED;
        ans.t = TIME_SAT;
      end else begin
        ans.st = ST_EXTRAPOLATED;
        ans.t = f_last + q[47:0];
      end
    end
  endtask

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send(input stim_row_t row);
    answer_t ans;
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= row.req;
    observed_position <= row.obs;
    wall_clock <= row.wc;
    target_position <= row.tgt;
    do @(posedge clk); while (!in_ready);
    if (row.req == REQ_OBSERVE) filter_observe(row.obs, row.wc, ans);
    else filter_crossing(row.tgt, ans);
    if (row.known) begin
      ans.st = row.st;
      ans.t = row.t;
    end
    pending_answers.push_back(ans);
  endtask

  task automatic add_row(input logic req, input logic [47:0] obs, input logic [47:0] wc,
                         input logic [47:0] tgt, input bit known, input logic [2:0] st,
                         input logic [47:0] t);
    stim_row_t row;
    row = '{req, obs, wc, tgt, known, st, t};
    dir_rows.push_back(row);
  endtask

  // registers change only with nothing in flight
  task automatic set_registers(input logic [31:0] v0, input logic [31:0] v1,
                               input logic [31:0] v2, input logic [31:0] v3);
    logic [31:0] vals[4];
    vals = '{v0, v1, v2, v3};
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (i[1:0])
        CFG_OBS_NOISE:  r_noise = vals[i];
        CFG_PROC_POS:   r_qpos = vals[i];
        CFG_PROC_RATE:  r_qrate = vals[i];
        CFG_INIT_RATEV: r_rv0 = vals[i];
        default:        r_noise = r_noise;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_items(input int count, input bit last_phase);
    stim_row_t row;
    int k;
    logic [47:0] dt;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      row = '{REQ_OBSERVE, pos_now, wc_now, pos_now, 0, ST_SEEDED, '0};
      dt = 48'($urandom_range(1, 1 << $urandom_range(20)));
      if (k < 55 || (k >= 94 && last_phase && n == count - 1)) begin
        wc_now += dt;
        pos_now += dt * 48'(rate_now);
        row.wc = wc_now;
        row.obs = pos_now + 48'($urandom_range(64)) - 48'd32;
      end else if (k < 78) begin
        row.req = REQ_PREDICT;
        row.tgt = pos_now + 48'($urandom_range(1 << 20)) - 48'd1000;
      end else if (k < 86) begin
        row.req = REQ_PREDICT;
        row.tgt = rand48();
      end else if (k < 93) begin
        row.wc = wc_now - 48'($urandom_range(wc_now > 5000 ? 5000 : 0));
        row.obs = rand48();
      end else begin
        wc_now += dt;
        row.wc = wc_now;
        row.obs = rand48();
      end
      if (last_phase && n == count - 1) row.wc = ALL48;
      row.req = row.req;
      send(row);
    end
  endtask

  // receiver: random backpressure plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1;
      hold_left <= 700;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report("unexpected beat", {45'd0, status}, '0);
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.st) report("status", {45'd0, status}, {45'd0, want.st});
        if (crossing_time !== want.t) report("crossing_time", crossing_time, want.t);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    filter_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_registers(32'd65536, 32'd65536, 32'd66, 32'hFFFF_FFFF);
    // not seeded, seeding, rejections, crossed, zero rate, large positions
    add_row(REQ_PREDICT, '0, '0, 48'd5, 1, ST_NOT_READY, TIME_ALL_ONES);
    add_row(REQ_PREDICT, '0, '0, ALL48, 1, ST_NOT_READY, TIME_ALL_ONES);
    add_row(REQ_OBSERVE, 48'd1000, 48'd100, '0, 1, ST_SEEDED, '0);
    add_row(REQ_OBSERVE, 48'd1010, 48'd100, '0, 1, ST_REJECTED, '0);
    add_row(REQ_OBSERVE, 48'd1010, 48'd0, '0, 1, ST_REJECTED, '0);
    add_row(REQ_PREDICT, '0, '0, 48'd0, 1, ST_CROSSED, 48'd100);
    add_row(REQ_PREDICT, '0, '0, 48'd1000, 1, ST_CROSSED, 48'd100);
    add_row(REQ_PREDICT, '0, '0, 48'd1001, 0, ST_SEEDED, '0);
    add_row(REQ_PREDICT, '0, '0, ALL48, 0, ST_SEEDED, '0);
    add_row(REQ_OBSERVE, 48'd1020, 48'd110, '0, 0, ST_SEEDED, '0);
    add_row(REQ_OBSERVE, 48'd1030, 48'd120, '0, 0, ST_SEEDED, '0);
    add_row(REQ_PREDICT, '0, '0, 48'd2000, 0, ST_SEEDED, '0);
    add_row(REQ_OBSERVE, ALL48, 48'd121, '0, 0, ST_SEEDED, '0);
    add_row(REQ_PREDICT, '0, '0, 48'h7FFF_FFFF_FFFF, 0, ST_SEEDED, '0);
    add_row(REQ_OBSERVE, 48'd0, 48'd200, '0, 0, ST_SEEDED, '0);
    add_row(REQ_PREDICT, '0, '0, ALL48, 0, ST_SEEDED, '0);
    add_row(REQ_OBSERVE, 48'd1200, 48'd400, '0, 0, ST_SEEDED, '0);
    add_row(REQ_PREDICT, '0, '0, 48'd1300, 0, ST_SEEDED, '0);
    foreach (dir_rows[i]) send(dir_rows[i]);

    wc_now = 48'd1000;
    pos_now = 48'd5000;
    rate_now = 1;
    random_items(310, 0);

    snd_idle = 54;
    rcv_idle = 10;
    set_registers(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    hold_req <= 1'b1;
    rate_now = 0;
    random_items(310, 0);

    snd_idle = 0;
    rcv_idle = 0;
    set_registers($urandom(), $urandom(), $urandom_range(4096), $urandom());
    rate_now = 3;
    random_items(310, 0);

    set_registers(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
    wc_now = 48'h8000_0000_0000 + 48'($urandom());
    rate_now = 2;
    random_items(310, 1);

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kcp_pkg.sv
rtl/kcp_mul.sv
rtl/kcp_div.sv
rtl/kalman_rate_crossing_predictor.sv
verif/kalman_rate_crossing_predictor_tb.sv
